/* hw/rtl/vector_clock_sibling_resolver_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vector clock sibling resolver.
// Checks are compiled in simulation and turn into nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef VECTOR_CLOCK_SIBLING_RESOLVER_UNIT_MACROS_SVH
`define VECTOR_CLOCK_SIBLING_RESOLVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define VCSR_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCSR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VCSR_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg)
`define VCSR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

/* hw/rtl/vcsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_pkg
// Sizes, types and codes shared by the sibling resolver modules.
// ----------------------------------------------------------------------------
package vcsr_pkg;

    // Storage shape.
    localparam int KEY_SLOTS     = 16;
    localparam int SIBLING_SLOTS = 4;
    localparam int CLOCK_NODES   = 4;

    // Fixed field widths of the channels.
    localparam int KEY_IN_W    = 4;
    localparam int VALUE_W     = 64;
    localparam int CLOCK_W     = 32;
    localparam int PORT_NODES  = 4;
    localparam int COUNT_OUT_W = 3;

    // Derived widths.
    localparam int KEY_W         = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W         = $clog2(SIBLING_SLOTS + 1);
    localparam int COMPACT_STEPS = (SIBLING_SLOTS > 1) ? SIBLING_SLOTS - 1 : 1;
    localparam int STEP_W        = (COMPACT_STEPS > 1) ? $clog2(COMPACT_STEPS) : 1;

    typedef logic [CLOCK_NODES-1:0][CLOCK_W-1:0] clk_vec_t;

    // One stored version.
    typedef struct packed {
        logic               tomb;
        logic [VALUE_W-1:0] value;
        clk_vec_t           clocks;
    } sib_entry_t;

    // One key's sibling list as held in the row memory.
    typedef sib_entry_t [SIBLING_SLOTS-1:0] sib_row_t;

    // Operation applied to every cell of the chain in the same cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SCAN,
        CELL_COMPACT,
        CELL_SHIFT,
        CELL_APPEND
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        sib_entry_t incoming;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_COMPACT,
        S_APPEND,
        S_WRITE,
        S_RD_FIRST,
        S_RESP
    } state_t;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // Key slot folded into the number of key slots, as a small table.
    function automatic logic [KEY_W-1:0] key_index(input logic [KEY_IN_W-1:0] key);
        logic [KEY_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < 2 ** KEY_IN_W; i++)
        begin
            if (key == KEY_IN_W'(i))
            begin
                idx = KEY_W'(i % KEY_SLOTS);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/vcsr_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr channel interfaces
// Valid/ready channels for the command and the response transactions.
// ----------------------------------------------------------------------------

// Command channel: a put or a read of one key slot.
interface vcsr_req_if;
    import vcsr_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [KEY_IN_W-1:0] key_slot;
    logic [VALUE_W-1:0]  value_handle;
    logic                is_delete;
    logic [CLOCK_W-1:0]  clock_node_0;
    logic [CLOCK_W-1:0]  clock_node_1;
    logic [CLOCK_W-1:0]  clock_node_2;
    logic [CLOCK_W-1:0]  clock_node_3;

    modport source (
        output valid, cmd, key_slot, value_handle, is_delete,
               clock_node_0, clock_node_1, clock_node_2, clock_node_3,
        input  ready
    );

    modport sink (
        input  valid, cmd, key_slot, value_handle, is_delete,
               clock_node_0, clock_node_1, clock_node_2, clock_node_3,
        output ready
    );
endinterface

// Response channel: one transaction per put, one per sibling on a read.
interface vcsr_rsp_if;
    import vcsr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COUNT_OUT_W-1:0] sibling_count;
    logic                   live;
    logic                   added;
    logic                   overflow;
    logic [VALUE_W-1:0]     out_value;
    logic                   out_tombstone;
    logic [CLOCK_W-1:0]     out_clock_0;
    logic [CLOCK_W-1:0]     out_clock_1;
    logic [CLOCK_W-1:0]     out_clock_2;
    logic [CLOCK_W-1:0]     out_clock_3;
    logic                   last;

    modport source (
        output valid, sibling_count, live, added, overflow, out_value, out_tombstone,
               out_clock_0, out_clock_1, out_clock_2, out_clock_3, last,
        input  ready
    );

    modport sink (
        input  valid, sibling_count, live, added, overflow, out_value, out_tombstone,
               out_clock_0, out_clock_1, out_clock_2, out_clock_3, last,
        output ready
    );
endinterface

/* hw/rtl/vcsr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_cell
// One sibling position: holds a version, compares its clock with the
// incoming clock and trades its contents with its neighbors.
// ----------------------------------------------------------------------------
module vcsr_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vcsr_pkg::cell_ctl_t  ctl,
    input  vcsr_pkg::sib_entry_t load_entry,
    input  logic                 load_valid,
    input  vcsr_pkg::sib_entry_t right_entry,
    input  logic                 right_valid,
    input  logic                 left_valid,
    input  logic                 stop_in,
    input  logic                 hole_in,
    output vcsr_pkg::sib_entry_t entry,
    output logic                 valid,
    output logic                 stop_out,
    output logic                 hole_out
);
    import vcsr_pkg::*;

    sib_entry_t entry_reg;
    sib_entry_t entry_next;
    logic       valid_reg;
    logic       valid_next;
    logic       in_gt;
    logic       sib_gt;
    logic       erase;

    // Clock comparison of the held sibling against the incoming version.
    always_comb
    begin
        in_gt  = 1'b0;
        sib_gt = 1'b0;
        for (int n = 0; n < CLOCK_NODES; n++)
        begin
            if (ctl.incoming.clocks[n] > entry_reg.clocks[n])
            begin
                in_gt = 1'b1;
            end
            else if (entry_reg.clocks[n] > ctl.incoming.clocks[n])
            begin
                sib_gt = 1'b1;
            end
        end
    end

    // A dominating sibling stops the scan for every cell to its right.
    assign stop_out = stop_in | (valid_reg & sib_gt & ~in_gt);
    assign erase    = valid_reg & ~stop_in & ~sib_gt;
    assign hole_out = hole_in | ~valid_reg;

    // Next contents for each chain operation.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctl.op)
            CELL_LOAD:
            begin
                entry_next = load_entry;
                valid_next = load_valid;
            end
            CELL_SCAN:
            begin
                if (erase)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_COMPACT:
            begin
                // A hole here or further left pulls the right neighbor in.
                if (hole_in || !valid_reg)
                begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            CELL_APPEND:
            begin
                // The first free position takes the incoming version.
                if (!valid_reg && left_valid)
                begin
                    entry_next = ctl.incoming;
                    valid_next = 1'b1;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Version payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

/* hw/rtl/vcsr_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_chain
// Row of sibling cells, position 0 at the head of the list, with the stop
// and hole signals rippling from the head toward the tail.
// ----------------------------------------------------------------------------
module vcsr_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vcsr_pkg::cell_ctl_t           ctl,
    input  vcsr_pkg::sib_row_t            load_row,
    input  logic [vcsr_pkg::CNT_W-1:0]    load_count,
    output vcsr_pkg::sib_row_t            row,
    output logic [vcsr_pkg::SIBLING_SLOTS-1:0] valid,
    output logic                          stop
);
    import vcsr_pkg::*;

    sib_entry_t               ent_ext [SIBLING_SLOTS+1];
    logic [SIBLING_SLOTS:0]   valid_ext;
    logic [SIBLING_SLOTS:0]   left_ext;
    logic [SIBLING_SLOTS:0]   stop_c;
    logic [SIBLING_SLOTS:0]   hole_c;

    // The tail sees an empty neighbor; the head always has a filled left side.
    assign ent_ext[SIBLING_SLOTS]   = '0;
    assign valid_ext[SIBLING_SLOTS] = 1'b0;
    assign left_ext                 = {valid_ext[SIBLING_SLOTS-1:0], 1'b1};
    assign stop_c[0]                = 1'b0;
    assign hole_c[0]                = 1'b0;

    for (genvar i = 0; i < SIBLING_SLOTS; i++)
    begin : g_cell
        logic cell_load_valid;

        // Positions below the stored count hold stored list entries.
        assign cell_load_valid = CNT_W'(i) < load_count;

        vcsr_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .load_entry  (load_row[i]),
            .load_valid  (cell_load_valid),
            .right_entry (ent_ext[i+1]),
            .right_valid (valid_ext[i+1]),
            .left_valid  (left_ext[i]),
            .stop_in     (stop_c[i]),
            .hole_in     (hole_c[i]),
            .entry       (ent_ext[i]),
            .valid       (valid_ext[i]),
            .stop_out    (stop_c[i+1]),
            .hole_out    (hole_c[i+1])
        );

        assign row[i] = ent_ext[i];
    end

    assign valid = valid_ext[SIBLING_SLOTS-1:0];
    assign stop  = stop_c[SIBLING_SLOTS] & (hole_c[SIBLING_SLOTS] | ~hole_c[SIBLING_SLOTS]);

endmodule

/* hw/rtl/vector_clock_sibling_resolver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_clock_sibling_resolver_unit
// Per-key lists of concurrent versions resolved by vector clock dominance.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one command transaction: a put (set or delete) or a read
//   of one key slot. response carries the results: one transaction for a put,
//   one per stored sibling for a read (one all-zero transaction for an empty
//   key), with last set on the final one.
//   Only one command is in flight. A key's list is read from the row memory
//   into a chain of SIBLING_SLOTS cells, worked on there and written back.
//   Put: load, a scan step in which every cell compares its clock with the
//   incoming clock, compaction steps that close the holes, an append step
//   and a write-back step, after which the response is valid.
//   Read: the first sibling is valid after the load and first-read steps, and
//   further siblings follow one per cycle while response.ready is high.
//   The compaction cycles of the cell chain set the put rate.
//   A stalled response holds its transaction; no command is taken until the
//   last response transaction has been accepted. Reset empties every list;
//   no clearing pass is needed since only per-key counts are reset.
// ----------------------------------------------------------------------------
`include "vector_clock_sibling_resolver_unit_macros.svh"

module vector_clock_sibling_resolver_unit (
    input logic          clk,
    input logic          rst_n,
    vcsr_req_if.sink     request,
    vcsr_rsp_if.source   response
);
    import vcsr_pkg::*;

    // Control state.
    state_t                state_reg;
    state_t                state_next;
    cell_op_t              ctl_op;
    logic                  req_ready;
    logic                  req_fire;
    logic                  rsp_fire;
    logic [STEP_W-1:0]     step_reg;
    logic                  step_done;
    logic                  stopped_reg;
    logic                  added_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic                  rsp_last_reg;

    // Command payload and list storage.
    logic                  cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      accept_key;
    sib_entry_t            in_entry;
    sib_entry_t            in_entry_reg;
    sib_row_t              rdata_reg;
    logic [CNT_W-1:0]      cnt_reg;
    sib_row_t              row_mem [KEY_SLOTS];
    logic [CNT_W-1:0]      counts_reg [KEY_SLOTS];
    logic [PORT_NODES-1:0][CLOCK_W-1:0] port_clk;

    // Chain view.
    cell_ctl_t                  ctl;
    sib_row_t                   cell_row;
    logic [SIBLING_SLOTS-1:0]   cell_valid;
    logic                       chain_stop;
    logic [CNT_W-1:0]           valid_count;
    logic                       live_now;

    // Response registers.
    logic [COUNT_OUT_W-1:0]     rsp_count_reg;
    logic                       rsp_live_reg;
    sib_entry_t                 rsp_entry_reg;
    logic [PORT_NODES-1:0][CLOCK_W-1:0] rsp_clk;

    assign req_fire   = request.valid & req_ready;
    assign rsp_fire   = (state_reg == S_RESP) & response.ready;
    assign accept_key = key_index(request.key_slot);
    assign step_done  = step_reg == STEP_W'(COMPACT_STEPS - 1);

    // Incoming version assembled from the command fields.
    assign port_clk = {request.clock_node_3, request.clock_node_2,
                       request.clock_node_1, request.clock_node_0};

    always_comb
    begin
        in_entry.tomb  = request.is_delete;
        in_entry.value = request.value_handle;
        for (int n = 0; n < CLOCK_NODES; n++)
        begin
            in_entry.clocks[n] = port_clk[n];
        end
    end

    // Cell chain.
    assign ctl = '{op: ctl_op, incoming: in_entry_reg};

    vcsr_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .load_row   (rdata_reg),
        .load_count (cnt_reg),
        .row        (cell_row),
        .valid      (cell_valid),
        .stop       (chain_stop)
    );

    // Sibling count and liveness of the list held in the chain.
    always_comb
    begin
        valid_count = '0;
        live_now    = 1'b0;
        for (int i = 0; i < SIBLING_SLOTS; i++)
        begin
            valid_count = valid_count + CNT_W'(cell_valid[i]);
            live_now    = live_now | (cell_valid[i] & ~cell_row[i].tomb);
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and chain operation.
    always_comb
    begin
        state_next = state_reg;
        ctl_op     = CELL_HOLD;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (request.valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ctl_op     = CELL_LOAD;
                state_next = (cmd_reg == CMD_READ) ? S_RD_FIRST : S_SCAN;
            end
            S_SCAN:
            begin
                ctl_op     = CELL_SCAN;
                state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                ctl_op = CELL_COMPACT;
                if (step_done)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (!stopped_reg)
                begin
                    ctl_op = CELL_APPEND;
                end
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_RESP;
            end
            S_RD_FIRST:
            begin
                if (cnt_reg != '0)
                begin
                    ctl_op = CELL_SHIFT;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (response.ready)
                begin
                    if (rsp_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl_op = CELL_SHIFT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencing flags and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            stopped_reg  <= 1'b0;
            added_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            remain_reg   <= '0;
            rsp_last_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    step_reg  <= '0;
                    added_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                S_SCAN:
                begin
                    stopped_reg <= chain_stop;
                end
                S_COMPACT:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                S_APPEND:
                begin
                    added_reg <= ~stopped_reg & ~(&cell_valid);
                    ovf_reg   <= ~stopped_reg & (&cell_valid);
                end
                S_WRITE:
                begin
                    rsp_last_reg <= 1'b1;
                end
                S_RD_FIRST:
                begin
                    rsp_last_reg <= (cnt_reg == '0) || (cnt_reg == CNT_W'(1));
                    remain_reg   <= cnt_reg - CNT_W'(1);
                end
                S_RESP:
                begin
                    if (rsp_fire && !rsp_last_reg)
                    begin
                        rsp_last_reg <= remain_reg == CNT_W'(1);
                        remain_reg   <= remain_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // Command capture and response payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg      <= request.cmd;
            key_reg      <= accept_key;
            in_entry_reg <= in_entry;
        end
        if (state_reg == S_WRITE)
        begin
            rsp_count_reg <= COUNT_OUT_W'(valid_count);
            rsp_live_reg  <= live_now;
            rsp_entry_reg <= '0;
        end
        else if (state_reg == S_RD_FIRST)
        begin
            rsp_count_reg <= COUNT_OUT_W'(cnt_reg);
            rsp_live_reg  <= live_now;
            rsp_entry_reg <= (cnt_reg != '0) ? cell_row[0] : '0;
        end
        else if (rsp_fire && !rsp_last_reg)
        begin
            rsp_entry_reg <= cell_row[0];
        end
    end

    // Per-key sibling counts; an empty count marks an absent key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                counts_reg[k] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                cnt_reg <= counts_reg[accept_key];
            end
            if (state_reg == S_WRITE)
            begin
                counts_reg[key_reg] <= valid_count;
            end
        end
    end

    // Row memory: one row per key, read at acceptance, written back once.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rdata_reg <= row_mem[accept_key];
        end
        if (state_reg == S_WRITE)
        begin
            row_mem[key_reg] <= cell_row;
        end
    end

    // Response port.
    always_comb
    begin
        rsp_clk = '0;
        for (int n = 0; n < CLOCK_NODES; n++)
        begin
            rsp_clk[n] = rsp_entry_reg.clocks[n];
        end
    end

    assign request.ready          = req_ready;
    assign response.valid         = state_reg == S_RESP;
    assign response.sibling_count = rsp_count_reg;
    assign response.live          = rsp_live_reg;
    assign response.added         = added_reg;
    assign response.overflow      = ovf_reg;
    assign response.out_value     = rsp_entry_reg.value;
    assign response.out_tombstone = rsp_entry_reg.tomb;
    assign response.out_clock_0   = rsp_clk[0];
    assign response.out_clock_1   = rsp_clk[1];
    assign response.out_clock_2   = rsp_clk[2];
    assign response.out_clock_3   = rsp_clk[3];
    assign response.last          = rsp_last_reg;

    // Commands are taken only while no response is pending.
    `VCSR_ASSERT_SAME(a_ready_excl, clk, rst_n, request.ready, !response.valid, "command taken while a response is pending")
    // A put never reports both an append and an overflow.
    `VCSR_ASSERT_SAME(a_add_ovf, clk, rst_n, response.valid, !(response.added && response.overflow), "added and overflow both set")
    // After compaction the occupied cells form a prefix of the chain.
    `VCSR_ASSERT_SAME(a_compact, clk, rst_n, state_reg == S_APPEND, (cell_valid & (cell_valid + SIBLING_SLOTS'(1))) == '0, "sibling list not compacted")
    // The final response transaction frees the block for the next command.
    `VCSR_ASSERT_NEXT(a_last_free, clk, rst_n, response.valid && response.ready && response.last, request.ready, "block not idle after final response")

endmodule
